// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clock and
// is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising clock edge.
`define SRSO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that post holds at the edge after one where pre held.
`define SRSO_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: sv/srso_pkg.sv
`timescale 1ns / 1ps

package srso_pkg;

   localparam int DEFAULT_MAX_SCREENS = 16;

   localparam int SEL_W      = 5;
   localparam int COORD_W    = 16;
   localparam int ENTRY_W    = 8;
   localparam int COUNT_W    = 5;
   localparam int DEFAULT_W  = 4;
   localparam int CSR_DATA_W = 5;
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 72;

   localparam logic [SEL_W-1:0]     SEL_NONE             = '1;
   localparam logic [COUNT_W-1:0]   SCREEN_COUNT_RESET   = 5'd1;
   localparam logic [DEFAULT_W-1:0] DEFAULT_SCREEN_RESET = 4'd0;

   typedef enum logic [1:0] {
      REQ_WRITE    = 2'd0,
      REQ_WINDOW   = 2'd1,
      REQ_POINT    = 2'd2,
      REQ_GEOMETRY = 2'd3
   } req_kind_type;

   typedef enum logic {
      CSR_SCREEN_COUNT   = 1'b0,
      CSR_DEFAULT_SCREEN = 1'b1
   } csr_addr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        [COORD_W-1:0] h;
      logic        [COORD_W-1:0] w;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } rect_type;

   typedef struct packed {
      logic                      point_mode;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic        [COORD_W-1:0] sw;
      logic        [COORD_W-1:0] sh;
   } query_type;

   typedef struct packed {
      logic clear;
      logic entry_valid;
   } scan_ctl_type;

   typedef struct packed {
      logic busy;
      logic found;
   } scan_stat_type;

endpackage

// File: sv/srso_scan.sv
`timescale 1ns / 1ps

module srso_scan #(
   parameter int IDX_W = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srso_pkg::scan_ctl_type  ctl,
   input  logic [IDX_W-1:0]        entry_index,
   input  srso_pkg::rect_type      entry,
   input  srso_pkg::query_type     query,
   output srso_pkg::scan_stat_type stat,
   output logic [IDX_W-1:0]        best_index
);

   import srso_pkg::*;

   localparam int END_W = COORD_W + 2;
   localparam int LEN_W = COORD_W + 3;

   logic signed [END_W-1:0] x_end, y_end, qx_end, qy_end;
   logic signed [END_W-1:0] hi_x, hi_y;
   logic signed [COORD_W-1:0] lo_x, lo_y;
   logic signed [LEN_W-1:0] len_x, len_y;
   logic pos_x, pos_y, inside_x, inside_y;

   logic                   s1_valid_ff, s1_ok_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   logic [COORD_W-1:0]     s1_iw_ff, s1_ih_ff;
   logic                   s2_valid_ff, s2_ok_ff;
   logic [IDX_W-1:0]       s2_idx_ff;
   logic [2*COORD_W-1:0]   s2_area_ff;
   logic                   found_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [2*COORD_W-1:0]   best_area_ff;
   logic                   take;

   always_comb begin
      x_end  = $signed(END_W'(entry.x)) + $signed({2'b00, entry.w});
      y_end  = $signed(END_W'(entry.y)) + $signed({2'b00, entry.h});
      qx_end = $signed(END_W'(query.px)) + $signed({2'b00, query.sw});
      qy_end = $signed(END_W'(query.py)) + $signed({2'b00, query.sh});
      lo_x   = (entry.x > query.px) ? entry.x : query.px;
      lo_y   = (entry.y > query.py) ? entry.y : query.py;
      hi_x   = (x_end < qx_end) ? x_end : qx_end;
      hi_y   = (y_end < qy_end) ? y_end : qy_end;
      len_x  = $signed(LEN_W'(hi_x)) - $signed(LEN_W'(lo_x));
      len_y  = $signed(LEN_W'(hi_y)) - $signed(LEN_W'(lo_y));
      pos_x  = (len_x > $signed(LEN_W'(0)));
      pos_y  = (len_y > $signed(LEN_W'(0)));
      inside_x = (query.px >= entry.x) && ($signed(END_W'(query.px)) < x_end);
      inside_y = (query.py >= entry.y) && ($signed(END_W'(query.py)) < y_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.entry_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= entry_index;
      s1_ok_ff   <= query.point_mode ? (inside_x && inside_y) : (pos_x && pos_y);
      s1_iw_ff   <= len_x[COORD_W-1:0];
      s1_ih_ff   <= len_y[COORD_W-1:0];
      s2_idx_ff  <= s1_idx_ff;
      s2_ok_ff   <= s1_ok_ff;
      s2_area_ff <= s1_iw_ff * s1_ih_ff;
   end

   assign take = s2_valid_ff && s2_ok_ff &&
                 (!found_ff || (!query.point_mode && (s2_area_ff > best_area_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff  <= s2_idx_ff;
         best_area_ff <= s2_area_ff;
      end
   end

   assign stat.busy   = s1_valid_ff || s2_valid_ff;
   assign stat.found  = found_ff;
   assign best_index  = best_idx_ff;

endmodule

// File: sv/screen_rect_overlap_select_unit.sv
`timescale 1ns / 1ps
// Screen rectangle table with window-overlap, point and geometry lookups.
// Requests arrive on the req_ stream, one result per request leaves on the
// rsp_ stream, and two registers (screen count, default screen) are set
// through the csr_ write channel, which is always ready. It is to be used
// only while no request is in flight; the block does not enforce this.
// The table is a single-port synchronous memory with one entry per screen.
// Write requests, absent-window queries, geometry queries and queries made
// while the screen count is zero skip the scan and go from the transfer
// straight to the done state, which loads the output register.
// Other window and point queries read the table one entry per cycle through a
// three-stage overlap, multiply and compare pipeline that covers the n live
// screens (the screen count, capped at MAX_SCREENS), then wait for the
// pipeline to drain before they reach the done state.
// One request is in flight at a time; a new one is taken once the previous
// result sits in the output register, even if the receiver has not taken it.
// When the receiver stalls, the finished result waits in the work stage and
// the block holds off further requests.
// Reset clears the handshake state and sets the screen count to 1 and the
// default screen to 0; table contents are undefined until written.
`include "assert_macros.svh"

module screen_rect_overlap_select_unit #(
   parameter int MAX_SCREENS = srso_pkg::DEFAULT_MAX_SCREENS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index, pos_x, pos_y, size_w, size_h
   input  logic [srso_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type, window_absent
   input  logic [srso_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // screen_index, rect_x, rect_y, rect_w, rect_h, zero fill
   output logic [srso_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  srso_pkg::csr_addr_type          csr_index,
   input  logic [srso_pkg::CSR_DATA_W-1:0] csr_data
);

   import srso_pkg::*;

   localparam int IDX_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
   localparam int CNT_W = $clog2(MAX_SCREENS + 1);
   localparam int NW    = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
   localparam logic [NW-1:0] MAX_N = NW'(MAX_SCREENS);

   rect_type mem [MAX_SCREENS];
   rect_type mem_rd_ff;

   logic [COUNT_W-1:0]   screen_count_ff;
   logic [DEFAULT_W-1:0] default_screen_ff;

   state_type     state_ff, state_in;
   req_kind_type  kind_ff, kind_in;
   query_type     query_ff;
   logic [NW-1:0] scan_cnt_ff, scan_cnt_in, scan_cnt_next;
   logic [SEL_W-1:0] pend_sel_ff, pend_sel_in;
   logic          use_scan_ff, use_scan_in;
   logic          geom_ok_ff, geom_ok_in;
   logic          rd_valid_ff;
   logic [IDX_W-1:0] rd_index_ff;
   logic          rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   req_kind_type  in_kind;
   logic          in_absent;
   logic [ENTRY_W-1:0] in_index;
   rect_type      in_rect;
   logic          req_fire, rsp_load, scan_clear, scan_issue;
   logic [NW-1:0] count_ext, n_live, index_ext, geom_entry;
   logic          geom_ok, write_ok;
   logic          mem_we, mem_re;
   logic [IDX_W-1:0] mem_raddr;
   logic [SEL_W-1:0] res_sel;
   rect_type      res_rect;

   scan_ctl_type  scan_ctl;
   scan_stat_type scan_stat;
   logic [IDX_W-1:0] best_index;

   assign in_kind   = req_kind_type'(req_tuser[1:0]);
   assign in_absent = req_tuser[2];
   assign in_index  = req_tdata[ENTRY_W-1:0];
   assign in_rect   = req_tdata[ENTRY_W +: $bits(rect_type)];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign count_ext  = NW'(screen_count_ff);
   assign n_live     = (count_ext < MAX_N) ? count_ext : MAX_N;
   assign index_ext  = NW'(in_index);
   assign geom_entry = (index_ext < n_live) ? index_ext : NW'(default_screen_ff);
   assign geom_ok    = (geom_entry < MAX_N);
   assign write_ok   = (index_ext < MAX_N);

   assign scan_issue = (state_ff == ST_SCAN);
   assign mem_we     = req_fire && (in_kind == REQ_WRITE) && write_ok;
   assign mem_re     = scan_issue || (req_fire && (in_kind == REQ_GEOMETRY) && geom_ok);
   assign mem_raddr  = scan_issue ? scan_cnt_ff[IDX_W-1:0] : geom_entry[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[in_index[IDX_W-1:0]] <= in_rect;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_count_ff   <= SCREEN_COUNT_RESET;
         default_screen_ff <= DEFAULT_SCREEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_COUNT:   screen_count_ff   <= csr_data[COUNT_W-1:0];
            CSR_DEFAULT_SCREEN: default_screen_ff <= csr_data[DEFAULT_W-1:0];
         endcase
      end
   end

   assign scan_cnt_next = scan_cnt_ff + NW'(1);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      scan_cnt_in = scan_cnt_ff;
      pend_sel_in = pend_sel_ff;
      use_scan_in = use_scan_ff;
      geom_ok_in  = geom_ok_ff;
      scan_clear  = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in     = in_kind;
               pend_sel_in = SEL_NONE;
               use_scan_in = 1'b0;
               geom_ok_in  = 1'b0;
               state_in    = ST_DONE;
               unique case (in_kind)
                  REQ_WRITE: begin
                  end
                  REQ_WINDOW, REQ_POINT: begin
                     if ((in_kind == REQ_WINDOW) && in_absent) begin
                        pend_sel_in = {1'b0, default_screen_ff};
                     end else if (n_live != '0) begin
                        use_scan_in = 1'b1;
                        scan_clear  = 1'b1;
                        scan_cnt_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  REQ_GEOMETRY: begin
                     geom_ok_in = geom_ok;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_next;
            if (scan_cnt_next == n_live) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !scan_stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      scan_cnt_ff <= scan_cnt_in;
      pend_sel_ff <= pend_sel_in;
      use_scan_ff <= use_scan_in;
      geom_ok_ff  <= geom_ok_in;
      rd_index_ff <= scan_cnt_ff[IDX_W-1:0];
      if (req_fire) begin
         query_ff.point_mode <= (in_kind == REQ_POINT);
         query_ff.px         <= in_rect.x;
         query_ff.py         <= in_rect.y;
         query_ff.sw         <= in_rect.w;
         query_ff.sh         <= in_rect.h;
      end
   end

   assign scan_ctl.clear       = scan_clear;
   assign scan_ctl.entry_valid = rd_valid_ff;

   srso_scan #(
      .IDX_W(IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .entry_index(rd_index_ff),
      .entry      (mem_rd_ff),
      .query      (query_ff),
      .stat       (scan_stat),
      .best_index (best_index)
   );

   always_comb begin
      if (use_scan_ff) begin
         res_sel = scan_stat.found ? SEL_W'(best_index) : SEL_NONE;
      end else begin
         res_sel = pend_sel_ff;
      end
      res_rect = ((kind_ff == REQ_GEOMETRY) && geom_ok_ff) ? mem_rd_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= RSP_DATA_W'({res_rect, res_sel});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SRSO_ASSERT(a_scan_in_range, (state_ff == ST_SCAN) |-> (scan_cnt_ff < n_live), "scan address past live count")
   `SRSO_ASSERT(a_done_drained, (state_ff == ST_DONE) |-> (!rd_valid_ff && !scan_stat.busy), "result taken before scan drained")
   `SRSO_ASSERT_NEXT(a_stall_holds, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_tready, state_ff == ST_DONE, "result dropped while output stalled")
   `SRSO_ASSERT_NEXT(a_transfer_busy, req_tvalid && req_tready, state_ff != ST_IDLE, "request transfer did not start work")

endmodule
